/* design/spi_pkg.sv */
package spi_pkg;

    // coordinate and register widths
    localparam int CB        = 21;
    localparam int CORNER_W  = 3 * CB;
    localparam int AREA_W    = 46;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    // corner count limits
    localparam logic [CNT_W-1:0] MIN_CORNERS = 3'd3;
    localparam logic [CNT_W-1:0] MAX_CORNERS = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AREA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd6;

    // shared arithmetic unit
    localparam int ALU_W      = 92;
    localparam int ALU_CNT_W  = 7;
    localparam int DIV_SHIFT  = 21;
    localparam int SQRT_TOP   = 90;
    localparam logic [ALU_CNT_W-1:0] MUL_STEPS  = 7'd45;
    localparam logic [ALU_CNT_W-1:0] DIV_STEPS  = 7'd22;
    localparam logic [ALU_CNT_W-1:0] SQRT_STEPS = 7'd46;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    // one coordinate of a packed corner
    function automatic logic signed [CB-1:0] coord(input logic [CORNER_W-1:0] w,
                                                    input logic [1:0] k);
        logic signed [CB-1:0] c;
        case (k)
            2'd0:    c = w[CB-1:0];
            2'd1:    c = w[2*CB-1:CB];
            default: c = w[3*CB-1:2*CB];
        endcase
        return c;
    endfunction

endpackage

/* design/spi_alu.sv */
module spi_alu import spi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_req         i_req,
    input  logic [ALU_W-1:0] i_opa,
    input  logic [ALU_W-1:0] i_opb,
    output logic             o_done,
    output logic [ALU_W-1:0] o_res
);

    logic [ALU_W-1:0]     r_x, r_y, r_z;
    logic [ALU_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [1:0]           r_op;

    logic [ALU_W-1:0] m;
    logic             sub;
    logic [ALU_W:0]   s;
    logic             ge;

    // one shared add/subtract with carry as compare
    always_comb begin
        m   = (r_op == OP_SQRT) ? (r_z | r_y) : r_y;
        sub = (r_op != OP_MUL);
        s   = {1'b0, r_x} + {1'b0, (sub ? ~m : m)} + {{ALU_W{1'b0}}, sub};
        ge  = s[ALU_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                unique case (i_req.op)
                    OP_MUL:  r_cnt <= MUL_STEPS;
                    OP_DIV:  r_cnt <= DIV_STEPS;
                    default: r_cnt <= SQRT_STEPS;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            unique case (i_req.op)
                OP_MUL: begin
                    r_x <= '0;
                    r_y <= i_opa;
                    r_z <= i_opb;
                end
                OP_DIV: begin
                    r_x <= i_opa;
                    r_y <= i_opb << DIV_SHIFT;
                    r_z <= '0;
                end
                default: begin
                    r_x <= i_opa;
                    r_y <= ALU_W'(1) << SQRT_TOP;
                    r_z <= '0;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    if (r_z[0]) begin
                        r_x <= s[ALU_W-1:0];
                    end
                    r_y <= r_y << 1;
                    r_z <= r_z >> 1;
                end
                OP_DIV: begin
                    if (ge) begin
                        r_x <= s[ALU_W-1:0];
                    end
                    r_z <= {r_z[ALU_W-2:0], ge};
                    r_y <= r_y >> 1;
                end
                default: begin
                    if (ge) begin
                        r_x <= s[ALU_W-1:0];
                        r_z <= (r_z >> 1) | r_y;
                    end else begin
                        r_z <= r_z >> 1;
                    end
                    r_y <= r_y >> 2;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_MUL) ? r_x : r_z;

endmodule

/* design/segment_polygon_intersection.sv */
// a segment that does not cross the plane ends after the plane distances; a crossing
//   also computes the crossing point and the fan triangles of the polygon
// throughput: one item at a time; every multiply, divide and square root runs in
//   the shared shift-add unit
// reset: synchronous active low; corners, area and tolerance clear, corner count is 4
module segment_polygon_intersection import spi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CORNER_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [CB-1:0] i_start_x,
    input  logic signed [CB-1:0] i_start_y,
    input  logic signed [CB-1:0] i_start_z,
    input  logic signed [CB-1:0] i_end_x,
    input  logic signed [CB-1:0] i_end_y,
    input  logic signed [CB-1:0] i_end_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic                 o_crosses_plane,
    output logic signed [CB-1:0] o_cross_x,
    output logic signed [CB-1:0] o_cross_y,
    output logic signed [CB-1:0] o_cross_z
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // program steps: normal, distances, crossing point, fan triangles
    localparam logic [4:0] P_N0A  = 5'd0;
    localparam logic [4:0] P_N0B  = 5'd1;
    localparam logic [4:0] P_N1A  = 5'd2;
    localparam logic [4:0] P_N1B  = 5'd3;
    localparam logic [4:0] P_N2A  = 5'd4;
    localparam logic [4:0] P_N2B  = 5'd5;
    localparam logic [4:0] P_DS0  = 5'd6;
    localparam logic [4:0] P_DS1  = 5'd7;
    localparam logic [4:0] P_DS2  = 5'd8;
    localparam logic [4:0] P_DE0  = 5'd9;
    localparam logic [4:0] P_DE1  = 5'd10;
    localparam logic [4:0] P_DE2  = 5'd11;
    localparam logic [4:0] P_NUM  = 5'd12;
    localparam logic [4:0] P_DIV  = 5'd13;
    localparam logic [4:0] P_C0A  = 5'd14;
    localparam logic [4:0] P_C0B  = 5'd15;
    localparam logic [4:0] P_C1A  = 5'd16;
    localparam logic [4:0] P_C1B  = 5'd17;
    localparam logic [4:0] P_C2A  = 5'd18;
    localparam logic [4:0] P_C2B  = 5'd19;
    localparam logic [4:0] P_Q0   = 5'd20;
    localparam logic [4:0] P_Q1   = 5'd21;
    localparam logic [4:0] P_Q2   = 5'd22;
    localparam logic [4:0] P_SQRT = 5'd23;

    localparam int AS_W   = 71;   // signed multiplicand
    localparam int BS_W   = 46;   // signed multiplier (normal, cross components)
    localparam int ACC_W  = 94;
    localparam int DIST_W = 72;
    localparam int T_W    = 70;
    localparam int SUM_W  = 48;

    // configuration registers
    logic [CORNER_W-1:0] r_ca, r_cb, r_cc, r_cd;
    logic [CNT_W-1:0]    r_count;
    logic [AREA_W-1:0]   r_area, r_tol;

    // control
    logic [2:0] r_state;
    logic [4:0] r_step;
    logic [1:0] r_k;
    logic [1:0] r_tri;
    logic       r_out_valid;

    // working values
    logic signed [CB-1:0]     r_ps [3];
    logic signed [CB-1:0]     r_pe [3];
    logic signed [CB-1:0]     r_pt [3];
    logic signed [BS_W-1:0]   r_n  [3];
    logic signed [BS_W-1:0]   r_cr [3];
    logic signed [DIST_W-1:0] r_ds, r_de;
    logic signed [ACC_W-1:0]  r_acc;
    logic [T_W-1:0]           r_t1m, r_t2m;
    logic                     r_t1n, r_t2n;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_hit, r_crs;

    // output register
    logic                 r_o_hit, r_o_crs;
    logic signed [CB-1:0] r_o_x, r_o_y, r_o_z;

    // shared unit
    t_alu_req         alu_req;
    logic [ALU_W-1:0] alu_opa, alu_opb, alu_res;
    logic             alu_done;

    // combinational operands
    logic signed [CB:0]     u [3], v [3], dps [3], dpe [3], ea [3], eb [3];
    logic [CORNER_W-1:0]    cor_a, cor_b;
    logic [CNT_W-1:0]       ncor;
    logic [1:0]             last_tri, nxt_tri;
    logic signed [AS_W-1:0] a_s;
    logic signed [BS_W-1:0] b_s;
    logic [AS_W-1:0]        a_abs;
    logic [BS_W-1:0]        b_abs;
    logic                   st_sub, st_clr;
    logic [1:0]             st_op;
    logic signed [ACC_W-1:0] acc_base, n_acc;
    logic signed [CB:0]     delta;
    logic [CB:0]            dabs;
    logic                   negq;
    logic signed [CB+1:0]   pt_new;
    logic                   above_s, above_e;
    logic signed [DIST_W:0] t2;
    logic [SUM_W-1:0]       target, tol2, diff;

    function automatic logic [CORNER_W-1:0] pick(input logic [1:0] i,
                                                 input logic [CORNER_W-1:0] a,
                                                 input logic [CORNER_W-1:0] b,
                                                 input logic [CORNER_W-1:0] c,
                                                 input logic [CORNER_W-1:0] d);
        logic [CORNER_W-1:0] r;
        case (i)
            2'd0:    r = a;
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    // corner count clamped to triangle or quadrilateral
    always_comb begin
        if (r_count < MIN_CORNERS) begin
            ncor = MIN_CORNERS;
        end else if (r_count > MAX_CORNERS) begin
            ncor = MAX_CORNERS;
        end else begin
            ncor = r_count;
        end
        last_tri = 2'(ncor - 3'd1);
        nxt_tri  = (r_tri == last_tri) ? 2'd0 : r_tri + 2'd1;
        cor_a    = pick(r_tri, r_ca, r_cb, r_cc, r_cd);
        cor_b    = pick(nxt_tri, r_ca, r_cb, r_cc, r_cd);
    end

    // edge vectors, endpoint offsets and fan triangle edges
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u[k]   = (CB+1)'(coord(r_ca, 2'(k))) - (CB+1)'(coord(r_cb, 2'(k)));
            v[k]   = (CB+1)'(coord(r_cc, 2'(k))) - (CB+1)'(coord(r_cb, 2'(k)));
            dps[k] = (CB+1)'(r_ps[k]) - (CB+1)'(coord(r_cb, 2'(k)));
            dpe[k] = (CB+1)'(r_pe[k]) - (CB+1)'(coord(r_cb, 2'(k)));
            ea[k]  = (CB+1)'(coord(cor_a, 2'(k))) - (CB+1)'(r_pt[k]);
            eb[k]  = (CB+1)'(coord(cor_b, 2'(k))) - (CB+1)'(r_pt[k]);
        end
        delta = (CB+1)'(r_ps[r_k]) - (CB+1)'(r_pe[r_k]);
        dabs  = delta[CB] ? (CB+1)'(-delta) : (CB+1)'(delta);
        negq  = r_t1n ^ delta[CB] ^ r_t2n;
    end

    // operand selection for each program step
    always_comb begin
        a_s    = '0;
        b_s    = '0;
        st_sub = 1'b0;
        st_clr = 1'b0;
        st_op  = OP_MUL;
        unique case (r_step)
            P_N0A:  begin a_s = AS_W'(u[1]); b_s = BS_W'(v[2]); st_clr = 1'b1; end
            P_N0B:  begin a_s = AS_W'(u[2]); b_s = BS_W'(v[1]); st_sub = 1'b1; end
            P_N1A:  begin a_s = AS_W'(u[2]); b_s = BS_W'(v[0]); st_clr = 1'b1; end
            P_N1B:  begin a_s = AS_W'(u[0]); b_s = BS_W'(v[2]); st_sub = 1'b1; end
            P_N2A:  begin a_s = AS_W'(u[0]); b_s = BS_W'(v[1]); st_clr = 1'b1; end
            P_N2B:  begin a_s = AS_W'(u[1]); b_s = BS_W'(v[0]); st_sub = 1'b1; end
            P_DS0:  begin a_s = AS_W'(dps[0]); b_s = r_n[0]; st_clr = 1'b1; end
            P_DS1:  begin a_s = AS_W'(dps[1]); b_s = r_n[1]; end
            P_DS2:  begin a_s = AS_W'(dps[2]); b_s = r_n[2]; end
            P_DE0:  begin a_s = AS_W'(dpe[0]); b_s = r_n[0]; st_clr = 1'b1; end
            P_DE1:  begin a_s = AS_W'(dpe[1]); b_s = r_n[1]; end
            P_DE2:  begin a_s = AS_W'(dpe[2]); b_s = r_n[2]; end
            P_NUM:  begin a_s = {1'b0, r_t1m}; b_s = BS_W'(dabs); st_clr = 1'b1; end
            P_DIV:  begin st_op = OP_DIV; end
            P_C0A:  begin a_s = AS_W'(ea[1]); b_s = BS_W'(eb[2]); st_clr = 1'b1; end
            P_C0B:  begin a_s = AS_W'(ea[2]); b_s = BS_W'(eb[1]); st_sub = 1'b1; end
            P_C1A:  begin a_s = AS_W'(ea[2]); b_s = BS_W'(eb[0]); st_clr = 1'b1; end
            P_C1B:  begin a_s = AS_W'(ea[0]); b_s = BS_W'(eb[2]); st_sub = 1'b1; end
            P_C2A:  begin a_s = AS_W'(ea[0]); b_s = BS_W'(eb[1]); st_clr = 1'b1; end
            P_C2B:  begin a_s = AS_W'(ea[1]); b_s = BS_W'(eb[0]); st_sub = 1'b1; end
            P_Q0:   begin a_s = AS_W'(r_cr[0]); b_s = r_cr[0]; st_clr = 1'b1; end
            P_Q1:   begin a_s = AS_W'(r_cr[1]); b_s = r_cr[1]; end
            P_Q2:   begin a_s = AS_W'(r_cr[2]); b_s = r_cr[2]; end
            P_SQRT: begin st_op = OP_SQRT; end
            default: begin end
        endcase
    end

    // magnitudes into the unit, signed accumulate of the product
    always_comb begin
        a_abs = a_s[AS_W-1] ? AS_W'(-a_s) : AS_W'(a_s);
        b_abs = b_s[BS_W-1] ? BS_W'(-b_s) : BS_W'(b_s);
        unique case (st_op)
            OP_MUL: begin
                alu_opa = ALU_W'(a_abs);
                alu_opb = ALU_W'(b_abs);
            end
            OP_DIV: begin
                alu_opa = r_acc[ALU_W-1:0];
                alu_opb = ALU_W'(r_t2m);
            end
            default: begin
                alu_opa = r_acc[ALU_W-1:0];
                alu_opb = '0;
            end
        endcase
        alu_req.start = (r_state == S_RUN);
        alu_req.op    = st_op;

        acc_base = st_clr ? '0 : r_acc;
        if (a_s[AS_W-1] ^ b_s[BS_W-1] ^ st_sub) begin
            n_acc = acc_base - $signed({2'b00, alu_res});
        end else begin
            n_acc = acc_base + $signed({2'b00, alu_res});
        end

        // crossing point from the quotient, always between the endpoints
        if (negq) begin
            pt_new = (CB+2)'(r_pe[r_k]) - $signed({1'b0, alu_res[CB:0]});
        end else begin
            pt_new = (CB+2)'(r_pe[r_k]) + $signed({1'b0, alu_res[CB:0]});
        end

        // a distance of zero counts as below the plane
        above_s = !r_ds[DIST_W-1] && (r_ds != '0);
        above_e = !r_de[DIST_W-1] && (r_de != '0);
        t2      = (DIST_W+1)'(r_ds) - (DIST_W+1)'(r_de);

        // area match in doubled units
        target = SUM_W'({r_area, 1'b0});
        tol2   = SUM_W'({r_tol, 1'b0});
        diff   = (r_sum >= target) ? r_sum - target : target - r_sum;
    end

    spi_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca    <= '0;
            r_cb    <= '0;
            r_cc    <= '0;
            r_cd    <= '0;
            r_count <= MAX_CORNERS;
            r_area  <= '0;
            r_tol   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CORNER_A: r_ca    <= i_cfg_data;
                REG_CORNER_B: r_cb    <= i_cfg_data;
                REG_CORNER_C: r_cc    <= i_cfg_data;
                REG_CORNER_D: r_cd    <= i_cfg_data;
                REG_COUNT:    r_count <= i_cfg_data[CNT_W-1:0];
                REG_AREA:     r_area  <= i_cfg_data[AREA_W-1:0];
                REG_TOL:      r_tol   <= i_cfg_data[AREA_W-1:0];
                default: begin end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= P_N0A;
            r_k         <= 2'd0;
            r_tri       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            // in the output state the slot is reloaded instead
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ps[0] <= i_start_x;
                        r_ps[1] <= i_start_y;
                        r_ps[2] <= i_start_z;
                        r_pe[0] <= i_end_x;
                        r_pe[1] <= i_end_y;
                        r_pe[2] <= i_end_z;
                        r_step  <= P_N0A;
                        r_tri   <= 2'd0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_done) begin
                        // after the end distance decide on crossing, after the
                        // last fan root compare the area
                        if (r_step == P_DE2) begin
                            r_state <= S_CHK;
                        end else if (r_step == P_SQRT && r_tri == last_tri) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RUN;
                        end
                        if (st_op == OP_MUL) begin
                            r_acc  <= n_acc;
                            r_step <= r_step + 5'd1;
                        end
                        unique case (r_step)
                            P_N0B: r_n[0]  <= n_acc[BS_W-1:0];
                            P_N1B: r_n[1]  <= n_acc[BS_W-1:0];
                            P_N2B: r_n[2]  <= n_acc[BS_W-1:0];
                            P_DS2: r_ds    <= n_acc[DIST_W-1:0];
                            P_DE2: r_de    <= n_acc[DIST_W-1:0];
                            P_C0B: r_cr[0] <= n_acc[BS_W-1:0];
                            P_C1B: r_cr[1] <= n_acc[BS_W-1:0];
                            P_C2B: r_cr[2] <= n_acc[BS_W-1:0];
                            P_DIV: begin
                                r_pt[r_k] <= pt_new[CB-1:0];
                                if (r_k == 2'd2) begin
                                    r_tri  <= 2'd0;
                                    r_step <= P_C0A;
                                end else begin
                                    r_k    <= r_k + 2'd1;
                                    r_step <= P_NUM;
                                end
                            end
                            P_SQRT: begin
                                r_sum <= r_sum + SUM_W'(alu_res);
                                if (r_tri != last_tri) begin
                                    r_tri  <= r_tri + 2'd1;
                                    r_step <= P_C0A;
                                end
                            end
                            default: begin end
                        endcase
                    end
                end
                S_CHK: begin
                    if (above_s == above_e) begin
                        r_hit   <= 1'b0;
                        r_crs   <= 1'b0;
                        r_pt[0] <= '0;
                        r_pt[1] <= '0;
                        r_pt[2] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // t1 = -d_end, t2 = d_start - d_end
                        r_t1n   <= above_e;
                        r_t1m   <= T_W'(r_de[DIST_W-1] ? -r_de : r_de);
                        r_t2n   <= t2[DIST_W];
                        r_t2m   <= T_W'(t2[DIST_W] ? -t2 : t2);
                        r_sum   <= '0;
                        r_k     <= 2'd0;
                        r_step  <= P_NUM;
                        r_state <= S_RUN;
                    end
                end
                S_FIN: begin
                    r_hit   <= (diff < tol2);
                    r_crs   <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the item until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_hit     <= r_hit;
                        r_o_crs     <= r_crs;
                        r_o_x       <= r_pt[0];
                        r_o_y       <= r_pt[1];
                        r_o_z       <= r_pt[2];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_crosses_plane = r_o_crs;
    assign o_cross_x       = r_o_x;
    assign o_cross_y       = r_o_y;
    assign o_cross_z       = r_o_z;

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside wait state");

    // fan triangle index stays below the active corner count
    a_tri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_tri <= last_tri))
        else $error("fan triangle index out of range");

    // crossing x lies between the two endpoints
    a_pt_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_crs) |->
            ((r_pt[0] >= r_ps[0] && r_pt[0] <= r_pe[0]) ||
             (r_pt[0] >= r_pe[0] && r_pt[0] <= r_ps[0])))
        else $error("crossing point outside segment");

    // no crossing means no hit and a zero point
    a_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_crs) |->
            (!r_hit && r_pt[0] == '0 && r_pt[1] == '0 && r_pt[2] == '0))
        else $error("result without crossing not cleared");

endmodule

/* dv/tb_segment_polygon_intersection.sv */
module tb_segment_polygon_intersection;
    import spi_pkg::*;

    typedef struct {
        bit                hit;
        bit                crosses;
        logic signed [CB-1:0] x, y, z;
    } t_crossing;

    typedef struct {
        logic [CORNER_W-1:0] corner [4];
        logic [CNT_W-1:0]    count;
        logic [AREA_W-1:0]   area;
        logic [AREA_W-1:0]   tol;
    } t_polygon;

    typedef struct {
        int        phase;
        longint    ps [3];
        longint    pe [3];
        bit        typed;
        t_crossing want;
    } t_segment_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CORNER_W-1:0]  i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [CB-1:0] i_start_x, i_start_y, i_start_z;
    logic signed [CB-1:0] i_end_x, i_end_y, i_end_z;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_hit;
    logic                 o_crosses_plane;
    logic signed [CB-1:0] o_cross_x, o_cross_y, o_cross_z;

    segment_polygon_intersection DUT (.*);

    // shadow of the configuration registers
    t_polygon  poly;
    t_crossing crossing_q [$];
    int        fails;
    int        results_seen;
    bit        burst;
    t_segment_row rows [$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #(80_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic longint corner_coord(logic [CORNER_W-1:0] w, int k);
        logic signed [CB-1:0] c;
        c = w[k*CB +: CB];
        return longint'(c);
    endfunction

    function automatic logic [CORNER_W-1:0] pack_corner(longint x, longint y, longint z);
        logic [CB-1:0] a, b, c;
        a = x[CB-1:0];
        b = y[CB-1:0];
        c = z[CB-1:0];
        return {c, b, a};
    endfunction

    function automatic longint clip21(longint v);
        if (v > 1048575) return 1048575;
        if (v < -1048576) return -1048576;
        return v;
    endfunction

    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] res, bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // twice the polygon area as seen from pt, summed over the fan triangles
    function automatic longint unsigned fan_area2(longint pt [3]);
        int n, nxt;
        longint a [3], b [3], cr [3];
        logic [127:0] sq, m;
        longint unsigned sum;
        n = poly.count < MIN_CORNERS ? 3 : (poly.count > MAX_CORNERS ? 4 : int'(poly.count));
        sum = 0;
        for (int i = 0; i < n; i++) begin
            nxt = (i + 1) % n;
            for (int k = 0; k < 3; k++) begin
                a[k] = corner_coord(poly.corner[i], k) - pt[k];
                b[k] = corner_coord(poly.corner[nxt], k) - pt[k];
            end
            cr[0] = a[1] * b[2] - a[2] * b[1];
            cr[1] = a[2] * b[0] - a[0] * b[2];
            cr[2] = a[0] * b[1] - a[1] * b[0];
            sq = 0;
            for (int k = 0; k < 3; k++) begin
                m = cr[k] < 0 ? 128'(-cr[k]) : 128'(cr[k]);
                sq = sq + m * m;
            end
            sum = sum + 64'(floor_sqrt(sq));
        end
        return sum;
    endfunction

    function automatic t_crossing intersect_segment(longint ps [3], longint pe [3]);
        t_crossing r;
        longint c0 [3], c1 [3], c2 [3], u [3], v [3], nv [3], pt [3], delta, qv;
        logic signed [127:0] ds, de, t1, t2, sa, sb;
        logic [127:0] at1, at2, ad, q;
        bit negq;
        longint unsigned sum, target, diff;
        for (int k = 0; k < 3; k++) begin
            c0[k] = corner_coord(poly.corner[0], k);
            c1[k] = corner_coord(poly.corner[1], k);
            c2[k] = corner_coord(poly.corner[2], k);
            u[k] = c0[k] - c1[k];
            v[k] = c2[k] - c1[k];
        end
        nv[0] = u[1] * v[2] - u[2] * v[1];
        nv[1] = u[2] * v[0] - u[0] * v[2];
        nv[2] = u[0] * v[1] - u[1] * v[0];
        ds = 0;
        de = 0;
        for (int k = 0; k < 3; k++) begin
            sb = nv[k];
            sa = ps[k] - c1[k];
            ds = ds + sa * sb;
            sa = pe[k] - c1[k];
            de = de + sa * sb;
        end
        r = '{default: 0};
        // zero distance counts as below, so only strictly positive is above
        if ((ds > 0) == (de > 0)) return r;
        t1 = -de;
        t2 = ds - de;
        at1 = t1 < 0 ? -t1 : t1;
        at2 = t2 < 0 ? -t2 : t2;
        for (int k = 0; k < 3; k++) begin
            delta = ps[k] - pe[k];
            ad = delta < 0 ? 128'(-delta) : 128'(delta);
            q = (at1 * ad) / at2;
            qv = longint'(q[39:0]);
            negq = ((t1 < 0) != (delta < 0)) != (t2 < 0);
            pt[k] = pe[k] + (negq ? -qv : qv);
        end
        sum = fan_area2(pt);
        target = 2 * longint'(poly.area);
        diff = sum >= target ? sum - target : target - sum;
        r.hit = diff < 2 * longint'(poly.tol);
        r.crosses = 1'b1;
        r.x = pt[0][CB-1:0];
        r.y = pt[1][CB-1:0];
        r.z = pt[2][CB-1:0];
        return r;
    endfunction

    // wait until the block has handed back everything it owes
    task automatic drain();
        while (crossing_q.size() > 0) @(posedge i_clk);
    endtask

    // drains pending results, writes every register back to back, then releases the write enable
    task automatic set_polygon(t_polygon p);
        i_in_valid <= 1'b0;
        drain();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            case (i)
                0: begin i_cfg_idx <= REG_CORNER_A; i_cfg_data <= p.corner[0]; end
                1: begin i_cfg_idx <= REG_CORNER_B; i_cfg_data <= p.corner[1]; end
                2: begin i_cfg_idx <= REG_CORNER_C; i_cfg_data <= p.corner[2]; end
                3: begin i_cfg_idx <= REG_CORNER_D; i_cfg_data <= p.corner[3]; end
                4: begin i_cfg_idx <= REG_COUNT;    i_cfg_data <= CORNER_W'(p.count); end
                5: begin i_cfg_idx <= REG_AREA;     i_cfg_data <= CORNER_W'(p.area); end
                default: begin i_cfg_idx <= REG_TOL; i_cfg_data <= CORNER_W'(p.tol); end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        poly = p;
    endtask

    task automatic send_segment(longint ps [3], longint pe [3], bit typed, t_crossing want);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= ps[0][CB-1:0];
        i_start_y <= ps[1][CB-1:0];
        i_start_z <= ps[2][CB-1:0];
        i_end_x <= pe[0][CB-1:0];
        i_end_y <= pe[1][CB-1:0];
        i_end_z <= pe[2][CB-1:0];
        do @(posedge i_clk); while (o_in_stall);
        crossing_q.push_back(typed ? want : intersect_segment(ps, pe));
    endtask

    function automatic void add_row(int ph, longint sx, longint sy, longint sz,
                                    longint ex, longint ey, longint ez, bit typed);
        t_segment_row r;
        r.phase = ph;
        r.ps = '{sx, sy, sz};
        r.pe = '{ex, ey, ez};
        r.typed = typed;
        r.want = '{default: 0};
        rows.push_back(r);
    endfunction

    // result side: random stalls, one long hold-off to back the block up
    initial begin : result_side
        int hold;
        int pressure;
        t_crossing w;
        hold = 0;
        pressure = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (crossing_q.size() == 0) begin
                    $error("result with nothing expected");
                    fails++;
                end else begin
                    w = crossing_q.pop_front();
                    if (o_hit !== w.hit) begin
                        $error("hit exp %0d got %0d", w.hit, o_hit); fails++;
                    end
                    if (o_crosses_plane !== w.crosses) begin
                        $error("crosses_plane exp %0d got %0d", w.crosses, o_crosses_plane);
                        fails++;
                    end
                    if (o_cross_x !== w.x) begin
                        $error("cross_x exp %0d got %0d", w.x, o_cross_x); fails++;
                    end
                    if (o_cross_y !== w.y) begin
                        $error("cross_y exp %0d got %0d", w.y, o_cross_y); fails++;
                    end
                    if (o_cross_z !== w.z) begin
                        $error("cross_z exp %0d got %0d", w.z, o_cross_z); fails++;
                    end
                end
                hold = burst ? 0 : $urandom_range(0, 14);
                if (results_seen == 60) pressure = 8000;
            end else if (hold > 0) begin
                hold--;
            end
            if (pressure > 0) pressure--;
            i_out_stall <= (hold > 0) || (pressure > 0);
        end
    end

    initial begin : stimulus
        t_polygon p;
        longint c0 [3], c1 [3], c2 [3], cp [3], ps [3], pe [3], w [3];
        longint unsigned s2;
        int kind, a, b, cur;
        t_crossing zero;
        zero = '{default: 0};
        fails = 0;
        results_seen = 0;
        burst = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        {i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z} = '0;
        poly.corner = '{default: 0};
        poly.count = MAX_CORNERS;
        poly.area = 0;
        poly.tol = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset all corners are zero, so the normal is zero and nothing crosses
        add_row(0, -1048576, -1048576, -1048576, 1048575, 1048575, 1048575, 1);
        add_row(0, 1048575, 0, -1048576, -1048576, 0, 1048575, 1);
        add_row(0, 0, 0, 0, 0, 0, 0, 1);
        // triangle in z = 0, above means negative z here
        add_row(1, 100, 100, -50, 100, 100, 50, 0);
        add_row(1, 200, 200, -1048576, 200, 200, 1048575, 0);
        add_row(1, 100, 100, -5, 300, 300, -10, 1);
        add_row(1, 10, 10, 0, 900, 20, 0, 1);
        add_row(1, 10, 10, 0, 10, 10, 40, 1);
        add_row(1, 50, 60, -10, 50, 60, 0, 0);
        add_row(1, 3000, 3000, -7, -3000, -900, 11, 0);
        // square with count above the limit, acts as four corners
        add_row(2, 500, 500, -20, 500, 500, 20, 0);
        add_row(2, 900, 100, 30, 900, 100, -30, 0);
        add_row(2, 5000, 500, -1, 5000, 500, 1, 0);
        add_row(2, -1048576, 1048575, 1048575, 1048575, -1048576, -1048576, 0);
        // same square with count below the limit, acts as a triangle
        add_row(3, 900, 900, -20, 900, 900, 20, 0);
        add_row(3, 100, 100, 20, 100, 100, -20, 0);
        add_row(3, 700, 100, 20, 700, 100, -20, 0);
        // collinear corners give a zero normal
        add_row(4, 0, 0, -100, 0, 0, 100, 1);
        add_row(4, -1048576, 5, 1048575, 1048575, 5, -1048576, 1);

        cur = 0;
        foreach (rows[i]) begin
            if (rows[i].phase != cur) begin
                cur = rows[i].phase;
                case (cur)
                    1: begin
                        p.corner = '{pack_corner(0, 0, 0), pack_corner(1000, 0, 0),
                                     pack_corner(0, 1000, 0), pack_corner(0, 0, 0)};
                        p.count = 3'd3; p.area = 500000; p.tol = 2000;
                    end
                    2: begin
                        p.corner = '{pack_corner(0, 0, 0), pack_corner(1000, 0, 0),
                                     pack_corner(1000, 1000, 0), pack_corner(0, 1000, 0)};
                        p.count = 3'd7; p.area = 1000000; p.tol = 10;
                    end
                    3: begin
                        p.count = 3'd0; p.area = 500000; p.tol = 1000;
                    end
                    default: begin
                        p.corner = '{pack_corner(0, 0, 0), pack_corner(10, 10, 10),
                                     pack_corner(20, 20, 20), pack_corner(-1, -1, -1)};
                        p.count = 3'd4; p.area = {AREA_W{1'b1}}; p.tol = {AREA_W{1'b1}};
                    end
                endcase
                set_polygon(p);
            end
            send_segment(rows[i].ps, rows[i].pe, rows[i].typed,
                         rows[i].typed ? zero : rows[i].want);
        end

        // random phases: a fresh polygon each, mostly segments through it
        for (int ph = 0; ph < 11; ph++) begin
            kind = $urandom_range(0, 5);
            burst = (ph % 3 == 1);
            for (int k = 0; k < 3; k++) begin
                if (kind == 5) begin
                    c0[k] = $signed($urandom_range(0, 2097151)) - 1048576;
                    c1[k] = $signed($urandom_range(0, 2097151)) - 1048576;
                    c2[k] = $signed($urandom_range(0, 2097151)) - 1048576;
                end else begin
                    c0[k] = $signed($urandom_range(0, 4000)) - 2000;
                    c1[k] = $signed($urandom_range(0, 4000)) - 2000;
                    c2[k] = $signed($urandom_range(0, 4000)) - 2000;
                end
            end
            if (kind == 4) for (int k = 0; k < 3; k++) c2[k] = 2 * c1[k] - c0[k];
            p.corner = '{pack_corner(c0[0], c0[1], c0[2]), pack_corner(c1[0], c1[1], c1[2]),
                         pack_corner(c2[0], c2[1], c2[2]),
                         pack_corner(clip21(c0[0] + c2[0] - c1[0]),
                                     clip21(c0[1] + c2[1] - c1[1]),
                                     clip21(c0[2] + c2[2] - c1[2]))};
            p.count = kind == 5 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(3, 4));
            poly = p;
            for (int k = 0; k < 3; k++) cp[k] = c1[k] + (c0[k] - c1[k] + c2[k] - c1[k]) / 4;
            s2 = fan_area2(cp);
            if (kind == 5) begin
                p.area = {$urandom, $urandom};
                p.tol = {$urandom, $urandom};
            end else begin
                p.area = s2 / 2;
                p.tol = {$urandom, $urandom} % (s2 / 16 + 2);
            end
            set_polygon(p);
            for (int n = 0; n < 48; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    for (int k = 0; k < 3; k++) begin
                        ps[k] = $signed($urandom_range(0, 2097151)) - 1048576;
                        pe[k] = $signed($urandom_range(0, 2097151)) - 1048576;
                    end
                end else begin
                    a = $urandom_range(0, 6);
                    b = $urandom_range(0, 6);
                    for (int k = 0; k < 3; k++) begin
                        cp[k] = c1[k] + ((c0[k] - c1[k]) * a + (c2[k] - c1[k]) * b) / 8;
                        w[k] = $signed($urandom_range(0, 1000)) - 500;
                        ps[k] = clip21(cp[k] + w[k]);
                        pe[k] = clip21(cp[k] - w[k]);
                    end
                end
                send_segment(ps, pe, 1'b0, zero);
            end
        end
        i_in_valid <= 1'b0;

        drain();
        repeat (3000) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
